// File: design/bsr_pkg.sv
// Package for the byte stream reassembler: sizes, state codes and the
// struct that travels with each released byte.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bsr_pkg;

    // Window store depth, a power of two so that a slot is the low index bits.
    localparam int WINDOW_DEPTH = 64;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths.
    localparam int IDX_W  = 32;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 7;
    localparam int POS_W  = IDX_W + 1;

    // Packed beat widths.
    localparam int IN_DATA_W  = IDX_W + BYTE_W;
    localparam int OUT_DATA_W = BYTE_W + 1 + CNT_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PROC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    // Status that belongs to a byte whose store read is in flight.
    typedef struct packed {
        logic             last;
        logic             closed;
        logic [CNT_W-1:0] held;
    } rel_meta_t;

endpackage

// File: design/bsr_window_ram.sv
// Window byte store: one write port and one read port with registered data.
// Depends on bsr_pkg for depth and widths.
`timescale 1ns / 1ps

module bsr_window_ram (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [bsr_pkg::SLOT_W-1:0]   wr_addr,
    input  logic [bsr_pkg::BYTE_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [bsr_pkg::SLOT_W-1:0]   rd_addr,
    output logic [bsr_pkg::BYTE_W-1:0]   rd_data
);

    logic [bsr_pkg::BYTE_W-1:0] mem [bsr_pkg::WINDOW_DEPTH];
    logic [bsr_pkg::BYTE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/byte_stream_reassembler.sv
// Byte stream reassembler: an item is taken only in idle, so the next item waits
// until the last beat of this one is loaded. The status result of an item that
// releases nothing is loaded into the output register from the processing state;
// released bytes follow the store read, one per cycle while m_tready allows.
// Reset (aresetn low, synchronous) clears the control state, the valid bits and
// the output valid flag; the byte store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module byte_stream_reassembler (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: window_size.
    input  logic                             cfg_we,
    input  logic [bsr_pkg::CFG_W-1:0]        cfg_wdata,
    // Input beats.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bsr_pkg::IN_DATA_W-1:0]    s_tdata,   // byte_index, byte_value
    input  logic                             s_tuser,   // has_byte
    input  logic                             s_tlast,   // ends_stream
    // Result beats.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bsr_pkg::OUT_DATA_W-1:0]   m_tdata,   // out_byte, stream_closed,
                                                        // pending_count
    output logic                             m_tuser,   // byte_valid
    output logic                             m_tlast    // last
);

    logic [1:0]                        state_reg, state_next;
    logic [bsr_pkg::CFG_W-1:0]         win_size_reg;
    logic [bsr_pkg::IDX_W-1:0]         ne_reg, ne_next;
    logic                              end_known_reg, end_known_next;
    logic [bsr_pkg::POS_W-1:0]         end_pos_reg, end_pos_next;
    logic                              closed_reg, closed_next;
    logic [bsr_pkg::CNT_W-1:0]         held_reg, held_next;
    logic [bsr_pkg::WINDOW_DEPTH-1:0]  valid_reg, valid_next;
    bsr_pkg::rel_meta_t                meta_reg, meta_next;
    logic                              m_valid_reg, m_valid_next;
    logic [bsr_pkg::OUT_DATA_W-1:0]    m_data_reg, m_data_next;
    logic                              m_user_reg, m_user_next;
    logic                              m_last_reg, m_last_next;

    logic                              in_acc;
    logic [bsr_pkg::IDX_W-1:0]         in_idx;
    logic [bsr_pkg::BYTE_W-1:0]        in_val;
    logic [bsr_pkg::SLOT_W-1:0]        in_slot;
    logic [bsr_pkg::CFG_W-1:0]         win;
    logic [bsr_pkg::POS_W-1:0]         ne_ext, ne_inc, win_end;
    logic                              end_known_acc;
    logic [bsr_pkg::POS_W-1:0]         end_pos_acc;
    logic                              closed_acc;
    logic                              store_ok;
    logic [bsr_pkg::SLOT_W-1:0]        ne_slot, ne_slot_inc;
    logic                              closed_rel;
    logic                              out_free;
    logic                              rel_go;
    logic [bsr_pkg::BYTE_W-1:0]        rd_data;

    // Input beat unpacking.
    assign in_acc  = s_tvalid && s_tready;
    assign in_idx  = s_tdata[bsr_pkg::IDX_W-1:0];
    assign in_val  = s_tdata[bsr_pkg::IDX_W +: bsr_pkg::BYTE_W];
    assign in_slot = in_idx[bsr_pkg::SLOT_W-1:0];

    // Effective window, capped at the store depth.
    assign win = (win_size_reg > bsr_pkg::CFG_W'(bsr_pkg::WINDOW_DEPTH)) ?
                 bsr_pkg::CFG_W'(bsr_pkg::WINDOW_DEPTH) : win_size_reg;

    assign ne_ext  = {1'b0, ne_reg};
    assign ne_inc  = ne_ext + bsr_pkg::POS_W'(1);
    assign win_end = ne_ext + bsr_pkg::POS_W'(win);

    // End marker is recorded and checked before the byte is stored.
    assign end_known_acc = end_known_reg | s_tlast;
    assign end_pos_acc   = s_tlast ? ({1'b0, in_idx} + bsr_pkg::POS_W'(s_tuser)) : end_pos_reg;
    assign closed_acc    = closed_reg | (end_known_acc && (end_pos_acc == ne_ext));

    // A byte is kept only inside the window and only into an empty slot.
    assign store_ok = !closed_acc && s_tuser && (in_idx != '1) &&
                      (in_idx >= ne_reg) && ({1'b0, in_idx} < win_end) &&
                      !valid_reg[in_slot];

    // Release lookahead on the next slot decides the last flag early.
    assign ne_slot     = ne_reg[bsr_pkg::SLOT_W-1:0];
    assign ne_slot_inc = ne_slot + bsr_pkg::SLOT_W'(1);
    assign closed_rel  = end_known_reg && (end_pos_reg == ne_inc);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == bsr_pkg::ST_IDLE);

    always_comb begin
        case (state_reg)
            bsr_pkg::ST_PROC: rel_go = !closed_reg && valid_reg[ne_slot];
            bsr_pkg::ST_READ: rel_go = out_free && !meta_reg.last;
            default:          rel_go = 1'b0;
        endcase
    end

    // Sequencer and state update.
    always_comb begin
        state_next     = state_reg;
        ne_next        = ne_reg;
        end_known_next = end_known_reg;
        end_pos_next   = end_pos_reg;
        closed_next    = closed_reg;
        held_next      = held_reg;
        valid_next     = valid_reg;
        meta_next      = meta_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;

        // Accepted item: end marker and store.
        if (in_acc) begin
            state_next = bsr_pkg::ST_PROC;
            if (!closed_reg) begin
                end_known_next = end_known_acc;
                end_pos_next   = end_pos_acc;
                closed_next    = closed_acc;
                if (store_ok) begin
                    valid_next[in_slot] = 1'b1;
                    held_next           = held_reg + bsr_pkg::CNT_W'(1);
                end
            end
        end

        // One release: read issued now, byte shows up next cycle.
        if (rel_go) begin
            valid_next[ne_slot] = 1'b0;
            held_next           = held_reg - bsr_pkg::CNT_W'(1);
            ne_next             = ne_reg + bsr_pkg::IDX_W'(1);
            closed_next         = closed_rel;
            meta_next.last      = closed_rel || !valid_reg[ne_slot_inc];
            meta_next.closed    = closed_rel;
            meta_next.held      = held_reg - bsr_pkg::CNT_W'(1);
        end

        case (state_reg)
            bsr_pkg::ST_PROC: begin
                if (rel_go) begin
                    state_next = bsr_pkg::ST_READ;
                end else if (out_free) begin
                    // Nothing to release: one status beat.
                    m_valid_next = 1'b1;
                    m_data_next  = {held_reg, closed_reg, bsr_pkg::BYTE_W'(0)};
                    m_user_next  = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = bsr_pkg::ST_IDLE;
                end
            end
            bsr_pkg::ST_READ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {meta_reg.held, meta_reg.closed, rd_data};
                    m_user_next  = 1'b1;
                    m_last_next  = meta_reg.last;
                    if (meta_reg.last) begin
                        state_next = bsr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bsr_pkg::ST_IDLE;
            win_size_reg  <= bsr_pkg::CFG_W'(64);
            ne_reg        <= '0;
            end_known_reg <= 1'b0;
            end_pos_reg   <= '0;
            closed_reg    <= 1'b0;
            held_reg      <= '0;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                win_size_reg <= cfg_wdata;
            end
            ne_reg        <= ne_next;
            end_known_reg <= end_known_next;
            end_pos_reg   <= end_pos_next;
            closed_reg    <= closed_next;
            held_reg      <= held_next;
            valid_reg     <= valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        meta_reg   <= meta_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    // Window byte store.
    bsr_window_ram u_window_ram (
        .aclk    (aclk),
        .wr_en   (in_acc && !closed_reg && store_ok),
        .wr_addr (in_slot),
        .wr_data (in_val),
        .rd_en   (rel_go),
        .rd_addr (ne_slot),
        .rd_data (rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // The held count always matches the number of occupied slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg == bsr_pkg::CNT_W'($countones(valid_reg)))
        else $error("held count differs from occupied slots");

    // A closed stream never reopens.
    assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg |=> closed_reg)
        else $error("stream reopened after close");

    // A status beat is always the final beat of its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("status beat without last");

endmodule
